>>> rtl/core/pmsc_pkg.sv
// ----------------------------------------------------------------------------
// pmsc_pkg : shared definitions for the sine/cosine phase modulator
// Widths, CORDIC constants, the arctangent table and the per-beat
// control bundle that travels alongside the rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pmsc_pkg;

    // field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int SENS_WIDTH   = 24;
    localparam int OUT_WIDTH    = 16;
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + SENS_WIDTH;

    // cordic datapath: full turn is 2^32, x/y in Q2.30 with headroom
    localparam int TURN_WIDTH = 32;
    localparam int ROT_STEPS  = 28;
    localparam int XY_WIDTH   = 34;
    localparam int Z_WIDTH    = TURN_WIDTH + 1;
    localparam int RND_SHIFT  = OUT_WIDTH - 1;

    localparam logic signed [XY_WIDTH-1:0] CORDIC_X0 = XY_WIDTH'(652032874);
    localparam logic signed [XY_WIDTH-1:0] RND_HALF  = XY_WIDTH'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [XY_WIDTH-1:0] Q15_MAX   = XY_WIDTH'(32767);
    localparam logic signed [XY_WIDTH-1:0] Q15_MIN   = -XY_WIDTH'(32768);

    localparam logic [TURN_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [TURN_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;

    // control bundle carried with each beat
    typedef struct packed {
        logic valid;
        logic neg;
        logic block_end;
    } pmsc_ctl_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [TURN_WIDTH-1:0] atan_turn(input int unsigned idx);
        logic [TURN_WIDTH-1:0] val;
        case (idx)
            0:       val = 32'h2000_0000;
            1:       val = 32'h12E4_051E;
            2:       val = 32'h09FB_385B;
            3:       val = 32'h0511_11D4;
            4:       val = 32'h028B_0D43;
            5:       val = 32'h0145_D7E1;
            6:       val = 32'h00A2_F61E;
            7:       val = 32'h0051_7C55;
            8:       val = 32'h0028_BE53;
            9:       val = 32'h0014_5F2F;
            10:      val = 32'h000A_2F98;
            11:      val = 32'h0005_17CC;
            12:      val = 32'h0002_8BE6;
            13:      val = 32'h0001_45F3;
            14:      val = 32'h0000_A2FA;
            15:      val = 32'h0000_517D;
            16:      val = 32'h0000_28BE;
            17:      val = 32'h0000_145F;
            18:      val = 32'h0000_0A30;
            19:      val = 32'h0000_0518;
            20:      val = 32'h0000_028C;
            21:      val = 32'h0000_0146;
            22:      val = 32'h0000_00A3;
            23:      val = 32'h0000_0051;
            24:      val = 32'h0000_0029;
            25:      val = 32'h0000_0014;
            26:      val = 32'h0000_000A;
            27:      val = 32'h0000_0005;
            default: val = '0;
        endcase
        return val;
    endfunction

    // round to q1.15, undo the fold and clamp
    function automatic logic signed [OUT_WIDTH-1:0] to_q15_sat(
        input logic signed [XY_WIDTH-1:0] v,
        input logic                       neg
    );
        logic signed [XY_WIDTH-1:0] r;
        logic signed [OUT_WIDTH-1:0] res;
        r = (v + RND_HALF) >>> RND_SHIFT;
        if (neg)
        begin
            r = -r;
        end
        if (r > Q15_MAX)
        begin
            res = Q15_MAX[OUT_WIDTH-1:0];
        end
        else if (r < Q15_MIN)
        begin
            res = Q15_MIN[OUT_WIDTH-1:0];
        end
        else
        begin
            res = r[OUT_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/phase_modulator_sincos_unit.sv
// ----------------------------------------------------------------------------
// phase_modulator_sincos_unit : sample-to-phase modulator, cos/sin output
// Scales each sample by the sensitivity, wraps it to a binary angle and
// produces its cosine and sine through a 28-step pipelined cordic.
// ----------------------------------------------------------------------------
// result path: input reg, multiply reg, fold reg, 28 rotation stages,
//   rounding/output reg
// throughput: one beat per cycle while sample_stall is low, set by the fully pipelined cordic
// sample_stall rises only once the output and its skid register both hold
//   a beat that the consumer has not taken
// reset clears all valid bits and loads sensitivity with zero
`default_nettype none

module phase_modulator_sincos_unit (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    sensitivity_we,
    input  wire logic signed [pmsc_pkg::SENS_WIDTH-1:0]  sensitivity_wdata,
    input  wire logic                                    sample_valid,
    output logic                                         sample_stall,
    input  wire logic signed [pmsc_pkg::SAMPLE_WIDTH-1:0] sample,
    input  wire logic                                    block_end,
    output logic                                         result_valid,
    input  wire logic                                    result_stall,
    output logic signed [pmsc_pkg::OUT_WIDTH-1:0]        in_phase,
    output logic signed [pmsc_pkg::OUT_WIDTH-1:0]        quadrature,
    output logic                                         block_end_out
);

    logic                                           en;
    logic                                           take_out;

    logic signed [pmsc_pkg::SENS_WIDTH-1:0]         sens_reg;

    logic                                           in_valid_reg;
    logic signed [pmsc_pkg::SAMPLE_WIDTH-1:0]       sample_reg;
    logic                                           block_end_reg;

    logic                                           prod_valid_reg;
    logic signed [pmsc_pkg::PROD_WIDTH-1:0]         prod_reg;
    logic                                           prod_be_reg;

    logic [pmsc_pkg::ANGLE_WIDTH-1:0]               angle;
    logic [pmsc_pkg::TURN_WIDTH-1:0]                turn;
    logic [pmsc_pkg::TURN_WIDTH-1:0]                turn_chk;
    logic [pmsc_pkg::TURN_WIDTH-1:0]                turn_fold;
    logic                                           fold;

    pmsc_pkg::pmsc_ctl_t                            fold_ctl_reg;
    pmsc_pkg::pmsc_ctl_t                            fold_ctl_next;
    logic signed [pmsc_pkg::Z_WIDTH-1:0]            z_reg;

    pmsc_pkg::pmsc_ctl_t                            rot_ctl;
    logic signed [pmsc_pkg::XY_WIDTH-1:0]           rot_x;
    logic signed [pmsc_pkg::XY_WIDTH-1:0]           rot_y;
    logic signed [pmsc_pkg::OUT_WIDTH-1:0]          cos_next;
    logic signed [pmsc_pkg::OUT_WIDTH-1:0]          sin_next;

    logic                                           res_valid_reg;
    logic signed [pmsc_pkg::OUT_WIDTH-1:0]          res_i_reg;
    logic signed [pmsc_pkg::OUT_WIDTH-1:0]          res_q_reg;
    logic                                           res_be_reg;

    logic                                           skid_valid_reg;
    logic signed [pmsc_pkg::OUT_WIDTH-1:0]          skid_i_reg;
    logic signed [pmsc_pkg::OUT_WIDTH-1:0]          skid_q_reg;
    logic                                           skid_be_reg;

    // whole pipeline moves while the skid register is free
    assign en           = ~skid_valid_reg;
    assign sample_stall = skid_valid_reg;
    assign take_out     = res_valid_reg & ~result_stall;

    // sensitivity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg <= '0;
        end
        else if (sensitivity_we)
        begin
            sens_reg <= sensitivity_wdata;
        end
    end

    // pipeline valid bits ahead of the cordic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            fold_ctl_reg   <= '0;
        end
        else if (en)
        begin
            in_valid_reg   <= sample_valid;
            prod_valid_reg <= in_valid_reg;
            fold_ctl_reg   <= fold_ctl_next;
        end
    end

    // input, multiply and fold payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg    <= sample;
            block_end_reg <= block_end;
            prod_reg      <= pmsc_pkg::PROD_WIDTH'(sample_reg)
                             * pmsc_pkg::PROD_WIDTH'(sens_reg);
            prod_be_reg   <= block_end_reg;
            z_reg         <= signed'({turn_fold[pmsc_pkg::TURN_WIDTH-1], turn_fold});
        end
    end

    // floor shift by sample_width-1, wrap to one turn, fold to +-1/4 turn
    always_comb
    begin
        angle     = prod_reg[pmsc_pkg::SAMPLE_WIDTH-1 +: pmsc_pkg::ANGLE_WIDTH];
        turn      = pmsc_pkg::TURN_WIDTH'(angle)
                    << (pmsc_pkg::TURN_WIDTH - pmsc_pkg::ANGLE_WIDTH);
        turn_chk  = turn + pmsc_pkg::QUARTER_TURN;
        fold      = turn_chk[pmsc_pkg::TURN_WIDTH-1];
        turn_fold = fold ? (turn ^ pmsc_pkg::HALF_TURN) : turn;

        fold_ctl_next.valid     = prod_valid_reg;
        fold_ctl_next.neg       = fold;
        fold_ctl_next.block_end = prod_be_reg;
    end

    pmsc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (fold_ctl_reg),
        .z_in    (z_reg),
        .ctl_out (rot_ctl),
        .x_out   (rot_x),
        .y_out   (rot_y)
    );

    // round, unfold and clamp
    assign cos_next = pmsc_pkg::to_q15_sat(rot_x, rot_ctl.neg);
    assign sin_next = pmsc_pkg::to_q15_sat(rot_y, rot_ctl.neg);

    // output and skid valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take_out)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (rot_ctl.valid)
        begin
            if (res_valid_reg && !take_out)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                res_valid_reg <= 1'b1;
            end
        end
        else if (take_out)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_out)
            begin
                res_i_reg  <= skid_i_reg;
                res_q_reg  <= skid_q_reg;
                res_be_reg <= skid_be_reg;
            end
        end
        else if (rot_ctl.valid)
        begin
            if (res_valid_reg && !take_out)
            begin
                skid_i_reg  <= cos_next;
                skid_q_reg  <= sin_next;
                skid_be_reg <= rot_ctl.block_end;
            end
            else
            begin
                res_i_reg  <= cos_next;
                res_q_reg  <= sin_next;
                res_be_reg <= rot_ctl.block_end;
            end
        end
    end

    assign result_valid  = res_valid_reg;
    assign in_phase      = res_i_reg;
    assign quadrature    = res_q_reg;
    assign block_end_out = res_be_reg;

endmodule

`default_nettype wire

>>> rtl/core/pmsc_cordic.sv
// ----------------------------------------------------------------------------
// pmsc_cordic : pipelined rotation-mode cordic
// One micro-rotation per stage, all stages advance together on enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsc_cordic (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire pmsc_pkg::pmsc_ctl_t                   ctl_in,
    input  wire logic signed [pmsc_pkg::Z_WIDTH-1:0]   z_in,
    output pmsc_pkg::pmsc_ctl_t                        ctl_out,
    output logic signed [pmsc_pkg::XY_WIDTH-1:0]       x_out,
    output logic signed [pmsc_pkg::XY_WIDTH-1:0]       y_out
);

    // stage boundaries: index 0 is the pipeline entry
    pmsc_pkg::pmsc_ctl_t                    ctl_s [0:pmsc_pkg::ROT_STEPS];
    logic signed [pmsc_pkg::XY_WIDTH-1:0]   x_s   [0:pmsc_pkg::ROT_STEPS];
    logic signed [pmsc_pkg::XY_WIDTH-1:0]   y_s   [0:pmsc_pkg::ROT_STEPS];
    logic signed [pmsc_pkg::Z_WIDTH-1:0]    z_s   [0:pmsc_pkg::ROT_STEPS-1];

    assign ctl_s[0] = ctl_in;
    assign x_s[0]   = pmsc_pkg::CORDIC_X0;
    assign y_s[0]   = '0;
    assign z_s[0]   = z_in;

    for (genvar i = 0; i < pmsc_pkg::ROT_STEPS; i++)
    begin : g_rot
        logic signed [pmsc_pkg::XY_WIDTH-1:0] dx;
        logic signed [pmsc_pkg::XY_WIDTH-1:0] dy;
        logic                                 up;
        pmsc_pkg::pmsc_ctl_t                  ctl_reg;
        logic signed [pmsc_pkg::XY_WIDTH-1:0] x_reg;
        logic signed [pmsc_pkg::XY_WIDTH-1:0] y_reg;

        // floor shifts for this step
        assign dx = y_s[i] >>> i;
        assign dy = x_s[i] >>> i;
        assign up = ~z_s[i][pmsc_pkg::Z_WIDTH-1];

        // control follows the data
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg <= '0;
            end
            else if (en)
            begin
                ctl_reg <= ctl_s[i];
            end
        end

        // micro-rotation
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg <= up ? (x_s[i] - dx) : (x_s[i] + dx);
                y_reg <= up ? (y_s[i] + dy) : (y_s[i] - dy);
            end
        end

        // residual angle, not needed after the last step
        if (i < pmsc_pkg::ROT_STEPS - 1)
        begin : g_z
            logic signed [pmsc_pkg::Z_WIDTH-1:0] da;
            logic signed [pmsc_pkg::Z_WIDTH-1:0] z_reg;

            // table angle for this step
            assign da = signed'({1'b0, pmsc_pkg::atan_turn(i)});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg <= up ? (z_s[i] - da) : (z_s[i] + da);
                end
            end

            assign z_s[i+1] = z_reg;
        end

        assign ctl_s[i+1] = ctl_reg;
        assign x_s[i+1]   = x_reg;
        assign y_s[i+1]   = y_reg;
    end

    assign ctl_out = ctl_s[pmsc_pkg::ROT_STEPS];
    assign x_out   = x_s[pmsc_pkg::ROT_STEPS];
    assign y_out   = y_s[pmsc_pkg::ROT_STEPS];

endmodule

`default_nettype wire

>>> rtl/core/pmsc_checker.sv
// ----------------------------------------------------------------------------
// pmsc_checker : port-level checks for the phase modulator
// Watches the handshakes on both channels and the back-pressure relation.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsc_checker (
    input wire logic                                     clk,
    input wire logic                                     rst_n,
    input wire logic                                     sample_stall,
    input wire logic                                     result_valid,
    input wire logic                                     result_stall,
    input wire logic signed [pmsc_pkg::OUT_WIDTH-1:0]    in_phase,
    input wire logic signed [pmsc_pkg::OUT_WIDTH-1:0]    quadrature,
    input wire logic                                     block_end_out
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(in_phase)
            && $stable(quadrature) && $stable(block_end_out))
        else $error("result beat changed while stalled");

    // input back-pressure only with a result waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // back-pressure starts only after the consumer stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(result_valid && result_stall))
        else $error("input stall rose without output stall");

    // a result leaving frees the input stall on the next edge
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall && !result_stall |=> !sample_stall)
        else $error("input stall held after result taken");

endmodule

bind phase_modulator_sincos_unit pmsc_checker u_pmsc_checker (.*);

`default_nettype wire

>>> test/tb_phase_modulator_sincos_unit.sv
// ----------------------------------------------------------------------------
// tb_phase_modulator_sincos_unit : self-checking bench for the phase modulator
// Drives signed samples under a series of sensitivity settings and compares
// each cos/sin output beat against an in-bench fixed-point cordic predictor,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_phase_modulator_sincos_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = pmsc_pkg::SAMPLE_WIDTH;
    localparam int NW = pmsc_pkg::SENS_WIDTH;
    localparam int OW = pmsc_pkg::OUT_WIDTH;

    localparam int  STEPS       = 28;
    localparam longint X_START  = 64'd652032874;
    localparam int  IDLE_PCT    = 16;
    localparam int  PIPE_DRAIN  = 40;
    localparam int  HOLD_CYCLES = 240;
    localparam int  HOLD_AT     = 300;
    localparam int  CALM_FROM   = 400;
    localparam int  CALM_TO     = 550;
    localparam int  RAND_PHASES = 7;
    localparam int  PHASE_BEATS = 100;
    localparam int  CYCLE_LIMIT = 200000;

    // arctangent of 2^-i, 2^-32 turn units
    localparam longint ROT_ANGLE [STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005
    };

    typedef struct packed {
        logic signed [SW-1:0] smp;
        logic                 be;
    } sample_beat_t;

    typedef struct packed {
        logic signed [OW-1:0] i;
        logic signed [OW-1:0] q;
        logic                 be;
    } iq_beat_t;

    logic                 clk               = 1'b0;
    logic                 rst_n             = 1'b0;
    logic                 sensitivity_we    = 1'b0;
    logic signed [NW-1:0] sensitivity_wdata = '0;
    logic                 sample_valid      = 1'b0;
    logic                 sample_stall;
    logic signed [SW-1:0] sample            = '0;
    logic                 block_end         = 1'b0;
    logic                 result_valid;
    logic                 result_stall      = 1'b0;
    logic signed [OW-1:0] in_phase;
    logic signed [OW-1:0] quadrature;
    logic                 block_end_out;

    sample_beat_t         pending_beats [$];
    iq_beat_t             expected_iq [$];
    sample_beat_t         drive_beat;
    iq_beat_t             want_iq;
    logic signed [NW-1:0] sens_model = '0;
    int                   in_count    = 0;
    int                   fail_count  = 0;
    int                   cycle_count = 0;
    int                   hold_left   = 0;
    logic                 hold_done   = 1'b0;
    logic                 calm;

    phase_modulator_sincos_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sensitivity_we    (sensitivity_we),
        .sensitivity_wdata (sensitivity_wdata),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample            (sample),
        .block_end         (block_end),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .in_phase          (in_phase),
        .quadrature        (quadrature),
        .block_end_out     (block_end_out)
    );

    // stretch of traffic with no idling on either side
    assign calm = (in_count >= CALM_FROM) && (in_count < CALM_TO);

    // rounding to q1.15, fold undo and clamp
    function automatic logic signed [OW-1:0] q15_round(input longint v, input logic neg);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (neg)
        begin
            r = -r;
        end
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[OW-1:0];
    endfunction

    // phase from sample and sensitivity, then cordic cos/sin
    function automatic iq_beat_t modulate(
        input logic signed [SW-1:0] smp,
        input logic signed [NW-1:0] sens,
        input logic                 be
    );
        longint      prod;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        logic [15:0] ang;
        logic [31:0] a32;
        logic        folded;
        iq_beat_t    r;
        prod   = (longint'(smp) * longint'(sens)) >>> (SW - 1);
        ang    = prod[15:0];
        a32    = {ang, 16'h0000};
        folded = 1'b0;
        // fold the angle into [-1/4, +1/4) turn
        if (((a32 + 32'h4000_0000) & 32'h8000_0000) != 32'h0)
        begin
            a32    = a32 + 32'h8000_0000;
            folded = 1'b1;
        end
        z = longint'($signed(a32));
        x = X_START;
        y = 0;
        for (int k = 0; k < STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ANGLE[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ANGLE[k];
            end
        end
        r.i  = q15_round(x, folded);
        r.q  = q15_round(y, folded);
        r.be = be;
        return r;
    endfunction

    // random sample, weighted towards the extremes and around zero
    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = {1'b1, {(SW-1){1'b0}}};
            1:       v = {1'b0, {(SW-1){1'b1}}};
            2:       v = SW'($urandom_range(0, 8)) - SW'(4);
            default: v = SW'($urandom());
        endcase
        return v;
    endfunction

    // clock
    initial
    begin
        forever
        begin
            #5ns clk = ~clk;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // input driver: next beat only once the current one has gone
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drive_beat = pending_beats.pop_front();
                sample_valid <= 1'b1;
                sample       <= drive_beat.smp;
                block_end    <= drive_beat.be;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // output receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (!hold_done && in_count >= HOLD_AT)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // monitor: register shadow, prediction on input beats, output checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sensitivity_we)
            begin
                sens_model <= sensitivity_wdata;
            end
            if (sample_valid && !sample_stall)
            begin
                expected_iq.push_back(modulate(sample, sens_model, block_end));
                in_count <= in_count + 1;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_iq.size() == 0)
                begin
                    $error("output beat with nothing expected: in_phase %0d quadrature %0d",
                           in_phase, quadrature);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want_iq = expected_iq.pop_front();
                    if (in_phase !== want_iq.i)
                    begin
                        $error("in_phase mismatch: expected %0d, actual %0d", want_iq.i, in_phase);
                        fail_count = fail_count + 1;
                    end
                    if (quadrature !== want_iq.q)
                    begin
                        $error("quadrature mismatch: expected %0d, actual %0d",
                               want_iq.q, quadrature);
                        fail_count = fail_count + 1;
                    end
                    if (block_end_out !== want_iq.be)
                    begin
                        $error("block_end_out mismatch: expected %0b, actual %0b",
                               want_iq.be, block_end_out);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    task automatic queue_beat(input logic signed [SW-1:0] smp, input logic be);
        sample_beat_t b;
        b.smp = smp;
        b.be  = be;
        pending_beats.push_back(b);
    endtask

    // wait until every queued beat has come out again
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_beats.size() != 0 || sample_valid || expected_iq.size() != 0);
    endtask

    task automatic write_sensitivity(input logic signed [NW-1:0] v);
        @(posedge clk);
        sensitivity_we    <= 1'b1;
        sensitivity_wdata <= v;
        @(posedge clk);
        sensitivity_we    <= 1'b0;
        @(negedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        logic signed [NW-1:0] s;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sensitivity: zero phase, cosine at full scale saturates
        queue_beat(-16'sd32768, 1'b1);
        queue_beat(16'sd32767, 1'b0);
        queue_beat(16'sd0, 1'b1);
        queue_beat(-16'sd1, 1'b0);
        drain();

        // unit gain: angle equals the sample, octant and fold edges
        write_sensitivity(24'sd32768);
        queue_beat(16'sh0000, 1'b0);
        queue_beat(16'sh2000, 1'b1);
        queue_beat(16'sh4000, 1'b0);
        queue_beat(16'sh6000, 1'b1);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'shA000, 1'b1);
        queue_beat(16'shC000, 1'b0);
        queue_beat(16'shE000, 1'b1);
        queue_beat(16'sh3FFF, 1'b0);
        queue_beat(16'sh4001, 1'b1);
        queue_beat(16'shBFFF, 1'b0);
        queue_beat(16'shC001, 1'b1);
        drain();

        // sensitivity extremes against sample extremes
        write_sensitivity(24'sh7FFFFF);
        queue_beat(-16'sd32768, 1'b1);
        queue_beat(16'sd32767, 1'b0);
        queue_beat(16'sd1, 1'b1);
        drain();
        write_sensitivity(24'sh800000);
        queue_beat(-16'sd32768, 1'b0);
        queue_beat(16'sd32767, 1'b1);
        queue_beat(-16'sd1, 1'b0);
        drain();

        // random phases, one sensitivity each
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       s = 24'sh7FFFFF;
                1:       s = 24'sh800000;
                2:       s = 24'sd1;
                3:       s = -24'sd1;
                4:       s = NW'($urandom_range(0, 131071) - 65536);
                default: s = NW'($urandom());
            endcase
            write_sensitivity(s);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                queue_beat(pick_sample(), ($urandom_range(0, 3) == 0));
            end
            drain();
        end

        repeat (PIPE_DRAIN) @(posedge clk);
        if (fail_count == 0 && expected_iq.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pmsc_pkg.sv
rtl/core/pmsc_cordic.sv
rtl/core/phase_modulator_sincos_unit.sv
rtl/core/pmsc_checker.sv
test/tb_phase_modulator_sincos_unit.sv
